>>> rtl/occ_pkg.sv
// shared types, constants and tables of the orbit camera controller
package occ_pkg;

   // fixed field widths
   localparam int POS_W   = 16;
   localparam int EYE_W   = 25;
   localparam int DIST_W  = 24;
   localparam int ELEV_W  = 23;
   localparam int ASTEP_W = 20;
   localparam int ZSTEP_W = 16;
   localparam int EMAX_W  = 22;

   // datapath widths
   localparam int CW = 34;          // cordic x, y, z and multiplicand width
   localparam int MW = 27;          // multiplier operand width, one bit per cycle
   localparam int PW = CW + MW;     // full product width

   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_STEP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ZOOM_STEP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ELEVATION_MAX = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ELEVATION_MIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DISTANCE_MIN = 3'd4;

   // event codes
   localparam logic OP_BUTTON = 1'b0;
   localparam logic OP_MOVE   = 1'b1;
   localparam logic [1:0] BTN_LEFT  = 2'd0;
   localparam logic [1:0] BTN_RIGHT = 2'd2;

   localparam logic [DIST_W-1:0] DIST_RESET = 24'd327680;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIR_MUL,
      S_ELEV_MUL,
      S_FAC_MUL,
      S_DIST_MUL,
      S_COS_A,
      S_COS_E,
      S_R_MUL,
      S_X_MUL,
      S_Y_MUL,
      S_Z_MUL,
      S_FIN
   } state_type;

   // atan(2^-i) in 2^-32 turn units
   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         5'd24: v = 32'd41;
         5'd25: v = 32'd20;
         5'd26: v = 32'd10;
         5'd27: v = 32'd5;
         5'd28: v = 32'd3;
         5'd29: v = 32'd1;
         5'd30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/occ_req_if.sv
// pointer event channel
interface occ_req_if;
   logic valid;
   logic ready;
   logic op;
   logic [1:0] button;
   logic pressed;
   logic signed [occ_pkg::POS_W-1:0] pos_x;
   logic signed [occ_pkg::POS_W-1:0] pos_y;

   modport source(output valid, op, button, pressed, pos_x, pos_y, input ready);
   modport sink(input valid, op, button, pressed, pos_x, pos_y, output ready);
endinterface

>>> rtl/occ_rsp_if.sv
// eye position result channel
interface occ_rsp_if;
   logic valid;
   logic ready;
   logic signed [occ_pkg::EYE_W-1:0] eye_x;
   logic signed [occ_pkg::EYE_W-1:0] eye_y;
   logic signed [occ_pkg::EYE_W-1:0] eye_z;

   modport source(output valid, eye_x, eye_y, eye_z, input ready);
   modport sink(input valid, eye_x, eye_y, eye_z, output ready);
endinterface

>>> rtl/occ_csr_if.sv
// configuration register write channel
interface occ_csr_if;
   logic valid;
   logic ready;
   logic [occ_pkg::CSR_IDX_W-1:0] index;
   logic [occ_pkg::CSR_DATA_W-1:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/occ_mul.sv
// bit-serial signed multiplier, one multiplier bit per cycle
module occ_mul (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [occ_pkg::CW-1:0] a,
   input  logic signed [occ_pkg::MW-1:0] b,
   output logic done,
   output logic signed [occ_pkg::PW-1:0] p
);
   localparam int CNT_W = $clog2(occ_pkg::MW);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic signed [occ_pkg::PW-1:0] a_ff, a_in;
   logic signed [occ_pkg::MW-1:0] b_ff, b_in;
   logic signed [occ_pkg::PW-1:0] acc_ff, acc_in;
   logic last;

   assign last = (cnt_ff == CNT_W'(occ_pkg::MW - 1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = occ_pkg::PW'(a);
         b_in    = b;
         acc_in  = '0;
      end else if (busy_ff) begin
         // sign bit of the multiplier carries negative weight
         if (b_ff[0]) begin
            acc_in = last ? acc_ff - a_ff : acc_ff + a_ff;
         end
         a_in   = a_ff <<< 1;
         b_in   = b_ff >>> 1;
         cnt_in = cnt_ff + CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign p    = acc_ff;

`ifndef ASSERT_OFF
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("multiplier started while busy");
   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("multiplier done while still busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("multiplier done held");
`endif
endmodule

>>> rtl/occ_cordic.sv
// iterative cordic, one rotation per cycle, gives cos and sin in q30
module occ_cordic #(
   parameter int CORDIC_STEPS = 20
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [31:0] angle,
   output logic done,
   output logic signed [occ_pkg::CW-1:0] cos_out,
   output logic signed [occ_pkg::CW-1:0] sin_out
);
   localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam logic signed [occ_pkg::CW-1:0] QUARTER = 34'sd1073741824;
   localparam logic signed [occ_pkg::CW-1:0] HALF    = 34'sd2147483648;

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic flip_ff, flip_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic signed [occ_pkg::CW-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [occ_pkg::CW-1:0] z0, at;

   always_comb begin
      z0 = occ_pkg::CW'($signed(angle));
      at = occ_pkg::CW'(occ_pkg::atan_turn(5'(step_ff)));
      busy_in = busy_ff;
      done_in = 1'b0;
      flip_in = flip_ff;
      step_in = step_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (start) begin
         // fold into a quarter turn either side of zero
         busy_in = 1'b1;
         step_in = '0;
         x_in = occ_pkg::CORDIC_GAIN;
         y_in = '0;
         if (z0 > QUARTER) begin
            z_in = z0 - HALF;
            flip_in = 1'b1;
         end else if (z0 < -QUARTER) begin
            z_in = z0 + HALF;
            flip_in = 1'b1;
         end else begin
            z_in = z0;
            flip_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - (y_ff >>> step_ff);
            y_in = y_ff + (x_ff >>> step_ff);
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + (y_ff >>> step_ff);
            y_in = y_ff - (x_ff >>> step_ff);
            z_in = z_ff + at;
         end
         step_in = step_ff + CNT_W'(1);
         if (step_ff == CNT_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      flip_ff <= flip_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign done    = done_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;

`ifndef ASSERT_OFF
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("cordic started while busy");
   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("cordic done while still busy");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff <= CNT_W'(CORDIC_STEPS - 1))
      else $error("cordic step count out of range");
`endif
endmodule

>>> rtl/orbit_camera_controller.sv
// orbit camera controller top level: event sequencer, state and result register
//
// usage
//   req_bus carries pointer events: a button transaction (op 0) sets or clears
//   the rotate flag (left) or zoom flag (right) and latches the position on a
//   press; a move transaction (op 1) rotates and/or zooms by the pixel delta
//   and recomputes the eye position. every request gives one rsp_bus
//   transaction with the eye position in signed q8.16. csr_bus writes the five
//   configuration registers by index; the user must write them only while the
//   block is idle, which the block itself does not enforce; its ready is always high.
// sequencing
//   a button transaction goes straight to finish. a move runs the direction and
//   elevation multiplies when rotating and the factor and distance multiplies
//   when zooming, then the shared cordic (one rotation per cycle) for both
//   angles, then the r, x, y and z multiplies. the bit-serial multiplier sets
//   most of the time, the cordic the rest. one request is worked on at a time.
// reset
//   synchronous, active high: angles zero, distance 5.0, flags clear, eye
//   (0, 0, 5.0), registers at their defaults; no clearing pass.
// stall
//   the result waits in an output register; a new request is taken while it
//   waits, and the one after it holds in finish until rsp_bus drains.
module orbit_camera_controller #(
   parameter int ANGLE_BITS   = 24,
   parameter int CORDIC_STEPS = 20
) (
   input  logic clock,
   input  logic reset,
   occ_req_if.sink   req_bus,
   occ_rsp_if.source rsp_bus,
   occ_csr_if.sink   csr_bus
);
   localparam int CW = occ_pkg::CW;
   localparam int MW = occ_pkg::MW;
   localparam int PW = occ_pkg::PW;
   localparam int EW = occ_pkg::EYE_W;
   localparam int DW = occ_pkg::DIST_W;
   localparam int LW = occ_pkg::ELEV_W;
   localparam int DXW = occ_pkg::POS_W + 1;
   localparam int FW = 34;   // zoom factor width

   // configuration registers
   logic [occ_pkg::ASTEP_W-1:0] astep_ff;
   logic [occ_pkg::ZSTEP_W-1:0] zstep_ff;
   logic [occ_pkg::EMAX_W-1:0]  emax_ff;
   logic signed [LW-1:0]        emin_ff;
   logic [DW-1:0]               dmin_ff;

   // camera state
   occ_pkg::state_type state_ff, state_in;
   logic launch_ff, launch_in;
   logic rot_ff, zoom_ff;
   logic [ANGLE_BITS-1:0] dir_ff;
   logic signed [LW-1:0] elev_ff;
   logic [DW-1:0] dist_ff;
   logic signed [occ_pkg::POS_W-1:0] prev_x_ff, prev_y_ff;
   logic signed [DXW-1:0] dx_ff, dy_ff;
   logic signed [FW-1:0] factor_ff;
   logic signed [CW-1:0] ca_ff, sa_ff, ce_ff, se_ff;
   logic signed [MW-1:0] r_ff;
   logic signed [EW-1:0] eye_x_ff, eye_y_ff, eye_z_ff;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [EW-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;

   // shared units
   logic mul_start, mul_done;
   logic signed [CW-1:0] mul_a;
   logic signed [MW-1:0] mul_b;
   logic signed [PW-1:0] mul_p;
   logic cor_start, cor_done;
   logic [31:0] cor_angle;
   logic signed [CW-1:0] cor_cos, cor_sin;

   logic req_take, mul_state, cor_state, unit_done, fin_go;

   // derived values
   logic signed [PW-1:0] q30_p, elev_sum, elev_max, elev_hi, elev_lo, dist_round;
   logic signed [PW-1:0] eye_val;
   logic [31:0] dir_turn, elev_turn;

   occ_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .p(mul_p)
   );

   occ_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cor_start), .angle(cor_angle),
      .done(cor_done), .cos_out(cor_cos), .sin_out(cor_sin)
   );

   assign req_bus.ready = (state_ff == occ_pkg::S_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.eye_x = rsp_x_ff;
   assign rsp_bus.eye_y = rsp_y_ff;
   assign rsp_bus.eye_z = rsp_z_ff;

   // angles widened to 32-bit turn units
   assign dir_turn  = 32'(dir_ff) << (32 - ANGLE_BITS);
   assign elev_turn = 32'(elev_ff) << (32 - ANGLE_BITS);

   assign mul_state = (state_ff == occ_pkg::S_DIR_MUL) || (state_ff == occ_pkg::S_ELEV_MUL)
      || (state_ff == occ_pkg::S_FAC_MUL) || (state_ff == occ_pkg::S_DIST_MUL)
      || (state_ff == occ_pkg::S_R_MUL) || (state_ff == occ_pkg::S_X_MUL)
      || (state_ff == occ_pkg::S_Y_MUL) || (state_ff == occ_pkg::S_Z_MUL);
   assign cor_state = (state_ff == occ_pkg::S_COS_A) || (state_ff == occ_pkg::S_COS_E);
   assign unit_done  = (mul_state && mul_done) || (cor_state && cor_done);
   assign fin_go     = (state_ff == occ_pkg::S_FIN) && (!rsp_valid_ff || rsp_bus.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         occ_pkg::S_IDLE: begin
            if (req_take) begin
               if (req_bus.op == occ_pkg::OP_MOVE) begin
                  state_in = rot_ff ? occ_pkg::S_DIR_MUL
                           : zoom_ff ? occ_pkg::S_FAC_MUL : occ_pkg::S_COS_A;
               end else begin
                  state_in = occ_pkg::S_FIN;
               end
            end
         end
         occ_pkg::S_DIR_MUL:  if (unit_done) state_in = occ_pkg::S_ELEV_MUL;
         occ_pkg::S_ELEV_MUL: if (unit_done) begin
            state_in = zoom_ff ? occ_pkg::S_FAC_MUL : occ_pkg::S_COS_A;
         end
         occ_pkg::S_FAC_MUL:  if (unit_done) state_in = occ_pkg::S_DIST_MUL;
         occ_pkg::S_DIST_MUL: if (unit_done) state_in = occ_pkg::S_COS_A;
         occ_pkg::S_COS_A:    if (unit_done) state_in = occ_pkg::S_COS_E;
         occ_pkg::S_COS_E:    if (unit_done) state_in = occ_pkg::S_R_MUL;
         occ_pkg::S_R_MUL:    if (unit_done) state_in = occ_pkg::S_X_MUL;
         occ_pkg::S_X_MUL:    if (unit_done) state_in = occ_pkg::S_Y_MUL;
         occ_pkg::S_Y_MUL:    if (unit_done) state_in = occ_pkg::S_Z_MUL;
         occ_pkg::S_Z_MUL:    if (unit_done) state_in = occ_pkg::S_FIN;
         occ_pkg::S_FIN:      if (fin_go) state_in = occ_pkg::S_IDLE;
         default:             state_in = occ_pkg::S_IDLE;
      endcase
   end

   // unit launch and operand selection
   always_comb begin
      mul_start = mul_state && !launch_ff;
      cor_start = cor_state && !launch_ff;
      launch_in = (state_in != state_ff) ? 1'b0 : (launch_ff || mul_start || cor_start);
      mul_a     = '0;
      mul_b     = '0;
      cor_angle = dir_turn;
      unique case (state_ff)
         occ_pkg::S_DIR_MUL: begin
            mul_a = CW'(dx_ff);
            mul_b = MW'(astep_ff);
         end
         occ_pkg::S_ELEV_MUL: begin
            mul_a = CW'(dy_ff);
            mul_b = MW'(astep_ff);
         end
         occ_pkg::S_FAC_MUL: begin
            mul_a = CW'(dy_ff);
            mul_b = MW'(zstep_ff);
         end
         occ_pkg::S_DIST_MUL: begin
            mul_a = CW'(factor_ff);
            mul_b = MW'(dist_ff);
         end
         occ_pkg::S_COS_E: cor_angle = elev_turn;
         occ_pkg::S_R_MUL: begin
            mul_a = ce_ff;
            mul_b = MW'(dist_ff);
         end
         occ_pkg::S_X_MUL: begin
            mul_a = sa_ff;
            mul_b = r_ff;
         end
         occ_pkg::S_Y_MUL: begin
            mul_a = se_ff;
            mul_b = MW'(dist_ff);
         end
         occ_pkg::S_Z_MUL: begin
            mul_a = ca_ff;
            mul_b = r_ff;
         end
         default: begin
         end
      endcase
   end

   // arithmetic on a finished product
   always_comb begin
      // q30 product rounded half up
      q30_p = (mul_p + PW'(64'sd536870912)) >>> 30;
      // elevation: limit to max first, then raise to min, compared signed
      elev_max = PW'($signed({1'b0, emax_ff}));
      elev_sum = PW'(elev_ff) + mul_p;
      elev_hi  = (elev_sum > elev_max) ? elev_max : elev_sum;
      elev_lo  = (elev_hi < PW'(emin_ff)) ? PW'(emin_ff) : elev_hi;
      // zoomed distance, rounded, saturated, floored at the minimum
      dist_round = (mul_p + PW'(64'sd32768)) >>> 16;
      // eye x is negated
      eye_val = (state_ff == occ_pkg::S_X_MUL) ? -q30_p : q30_p;
   end

   function automatic logic signed [EW-1:0] sat_eye(input logic signed [PW-1:0] v);
      logic signed [EW-1:0] r;
      if (v > PW'(64'sd16777215)) r = EW'(25'sd16777215);
      else if (v < PW'(-64'sd16777216)) r = EW'(-25'sd16777216);
      else r = EW'(v);
      return r;
   endfunction

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_bus.ready) rsp_valid_in = 1'b0;
      if (fin_go) rsp_valid_in = 1'b1;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= occ_pkg::S_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         astep_ff <= 20'd21361;
         zstep_ff <= 16'd197;
         emax_ff  <= 22'd4005316;
         emin_ff  <= -23'sd4005316;
         dmin_ff  <= 24'd65536;
      end else if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.index)
            occ_pkg::REG_ANGLE_STEP:    astep_ff <= csr_bus.data[occ_pkg::ASTEP_W-1:0];
            occ_pkg::REG_ZOOM_STEP:     zstep_ff <= csr_bus.data[occ_pkg::ZSTEP_W-1:0];
            occ_pkg::REG_ELEVATION_MAX: emax_ff  <= csr_bus.data[occ_pkg::EMAX_W-1:0];
            occ_pkg::REG_ELEVATION_MIN: emin_ff  <= csr_bus.data[LW-1:0];
            occ_pkg::REG_DISTANCE_MIN:  dmin_ff  <= csr_bus.data[DW-1:0];
            default: begin
            end
         endcase
      end
   end

   // camera state and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff    <= 1'b0;
         zoom_ff   <= 1'b0;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         dir_ff    <= '0;
         elev_ff   <= '0;
         dist_ff   <= occ_pkg::DIST_RESET;
         eye_x_ff  <= '0;
         eye_y_ff  <= '0;
         eye_z_ff  <= EW'(occ_pkg::DIST_RESET);
      end else begin
         if (req_take) begin
            if (req_bus.op == occ_pkg::OP_MOVE) begin
               prev_x_ff <= req_bus.pos_x;
               prev_y_ff <= req_bus.pos_y;
            end else if (req_bus.button == occ_pkg::BTN_LEFT
                         || req_bus.button == occ_pkg::BTN_RIGHT) begin
               if (req_bus.pressed) begin
                  prev_x_ff <= req_bus.pos_x;
                  prev_y_ff <= req_bus.pos_y;
               end
               if (req_bus.button == occ_pkg::BTN_LEFT) rot_ff <= req_bus.pressed;
               else zoom_ff <= req_bus.pressed;
            end
         end
         if (unit_done) begin
            case (state_ff)
               occ_pkg::S_DIR_MUL:  dir_ff  <= dir_ff + mul_p[ANGLE_BITS-1:0];
               occ_pkg::S_ELEV_MUL: elev_ff <= elev_lo[LW-1:0];
               occ_pkg::S_DIST_MUL: begin
                  if (mul_p < 0) dist_ff <= dmin_ff;
                  else if (dist_round > PW'(64'sd16777215)) dist_ff <= '1;
                  else if (dist_round < PW'(dmin_ff)) dist_ff <= dmin_ff;
                  else dist_ff <= dist_round[DW-1:0];
               end
               occ_pkg::S_X_MUL: eye_x_ff <= sat_eye(eye_val);
               occ_pkg::S_Y_MUL: eye_y_ff <= sat_eye(eye_val);
               occ_pkg::S_Z_MUL: eye_z_ff <= sat_eye(eye_val);
               default: begin
               end
            endcase
         end
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         dx_ff <= DXW'(req_bus.pos_x) - DXW'(prev_x_ff);
         dy_ff <= DXW'(req_bus.pos_y) - DXW'(prev_y_ff);
      end
      if (unit_done) begin
         case (state_ff)
            occ_pkg::S_FAC_MUL: factor_ff <= FW'(64'sd65536) + FW'(mul_p);
            occ_pkg::S_COS_A: begin
               ca_ff <= cor_cos;
               sa_ff <= cor_sin;
            end
            occ_pkg::S_COS_E: begin
               ce_ff <= cor_cos;
               se_ff <= cor_sin;
            end
            occ_pkg::S_R_MUL: r_ff <= q30_p[MW-1:0];
            default: begin
            end
         endcase
      end
      if (fin_go) begin
         rsp_x_ff <= eye_x_ff;
         rsp_y_ff <= eye_y_ff;
         rsp_z_ff <= eye_z_ff;
      end
   end

`ifndef ASSERT_OFF
   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != occ_pkg::S_IDLE) else $error("request taken but block idle");
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == occ_pkg::S_FIN))
      else $error("result raised outside finish");
   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mul_start && cor_start)) else $error("both units launched at once");
   a_dist_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == occ_pkg::S_DIST_MUL && unit_done) |=> dist_ff >= dmin_ff)
      else $error("distance below minimum after zoom");
`endif
endmodule
